// ----- rtl/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// clocked check that also runs during reset
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("%m: check failed");

`endif

// ----- rtl/cstp_pkg.sv -----
// shared constants and codes of the call stack profiler
package cstp_pkg;

    localparam int MAX_FUNCS_DEF   = 128;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF   = 48;

    localparam int CALLS_W   = 32;
    localparam int ACTION_W  = 3;
    localparam int FUNC_ID_W = 7;
    localparam int STATUS_W  = 2;

    localparam logic [ACTION_W-1:0] ACT_INIT     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REGISTER = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_START    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_END      = 3'd3;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_REG    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ACTIVE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 2'd3;

endpackage

// ----- rtl/cstp_entry_ram.sv -----
// function table memory, one read and one write port, with write bypass
module cstp_entry_ram #(
    parameter int DEPTH = cstp_pkg::MAX_FUNCS_DEF,
    parameter int WIDTH = 3 * cstp_pkg::TIME_BITS_DEF + 1 + cstp_pkg::CALLS_W,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [WIDTH-1:0]  q_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              byp_vld_reg;
    logic [ADDR_W-1:0] byp_addr_reg;
    logic [WIDTH-1:0]  byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg       <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // last write, covers a read issued on the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_vld_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            byp_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_addr_reg <= wr_addr;
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = (byp_vld_reg && (byp_addr_reg == rd_addr_reg)) ? byp_data_reg : q_reg;

endmodule

// ----- rtl/cstp_frame_ram.sv -----
// call stack frame memory, two read ports and one write port, with write bypass
module cstp_frame_ram #(
    parameter int DEPTH = cstp_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = 2 * cstp_pkg::TIME_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0]  mem [DEPTH];
    logic [WIDTH-1:0]  qa_reg;
    logic [WIDTH-1:0]  qb_reg;
    logic [ADDR_W-1:0] addr_a_reg;
    logic [ADDR_W-1:0] addr_b_reg;
    logic              byp_vld_reg;
    logic [ADDR_W-1:0] byp_addr_reg;
    logic [WIDTH-1:0]  byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            qa_reg     <= mem[rd_addr_a];
            qb_reg     <= mem[rd_addr_b];
            addr_a_reg <= rd_addr_a;
            addr_b_reg <= rd_addr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_vld_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            byp_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byp_addr_reg <= wr_addr;
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data_a = (byp_vld_reg && (byp_addr_reg == addr_a_reg)) ? byp_data_reg : qa_reg;
    assign rd_data_b = (byp_vld_reg && (byp_addr_reg == addr_b_reg)) ? byp_data_reg : qb_reg;

endmodule

// ----- rtl/call_stack_self_time_profiler.sv -----
// Call stack profiler with per-function inclusive and self time. Each event
// item is answered by exactly one result item. When results are taken
// promptly, on acceptance the function table memory and two entries of the
// frame memory (top and parent frame) are read, the next cycle forms the
// time differences, and the cycle after that sums, writes both memories
// back and loads the result register, while the next item is already
// accepted. A write bypass in each memory covers a read on the same edge.
// Registered and active marks sit in flip-flops cleared by reset, so no
// clearing pass follows reset. A new item is accepted while the previous
// result waits in the output register; the write-back cycle holds only while
// that register is still full.
module call_stack_self_time_profiler #(
    parameter int MAX_FUNCS   = cstp_pkg::MAX_FUNCS_DEF,
    parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = cstp_pkg::TIME_BITS_DEF,
    localparam int SDEPTH_W   = $clog2(STACK_DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cstp_pkg::ACTION_W-1:0]     action,
    input  logic [cstp_pkg::FUNC_ID_W-1:0]    func_id,
    input  logic [TIME_BITS-1:0]              timestamp,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cstp_pkg::STATUS_W-1:0]     status,
    output logic [TIME_BITS-1:0]              inclusive_total,
    output logic signed [TIME_BITS:0]         self_total,
    output logic [cstp_pkg::CALLS_W-1:0]      calls,
    output logic                              is_active,
    output logic                              is_registered,
    output logic [SDEPTH_W-1:0]               stack_level
);

    localparam int FIDX_W    = $clog2(MAX_FUNCS);
    localparam int ID_EXT_W  = ((FIDX_W > cstp_pkg::FUNC_ID_W) ? FIDX_W
                                                                : cstp_pkg::FUNC_ID_W) + 1;
    localparam int SIDX_W    = $clog2(STACK_DEPTH);
    localparam int SELF_W    = TIME_BITS + 1;
    localparam int CALLS_W   = cstp_pkg::CALLS_W;
    localparam int ENTRY_W   = 2 * TIME_BITS + SELF_W + CALLS_W;
    localparam int FRAME_W   = 2 * TIME_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIFF = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic in_accept;
    logic s2_go;

    // captured item
    logic [cstp_pkg::ACTION_W-1:0] action_reg;
    logic [FIDX_W-1:0]             idx_reg;
    logic                          valid_id_reg;
    logic [TIME_BITS-1:0]          ts_reg;

    logic [ID_EXT_W-1:0] id_ext;
    logic [FIDX_W-1:0]   idx_in;
    logic                id_ok;

    logic [MAX_FUNCS-1:0] reg_marks_reg;
    logic [MAX_FUNCS-1:0] reg_marks_next;
    logic [MAX_FUNCS-1:0] act_marks_reg;
    logic [MAX_FUNCS-1:0] act_marks_next;
    logic [SDEPTH_W-1:0]  depth_reg;
    logic [SDEPTH_W-1:0]  depth_next;
    logic [SDEPTH_W-1:0]  rd_depth;
    logic [SDEPTH_W-1:0]  rd_top;
    logic [SDEPTH_W-1:0]  rd_parent;
    logic [SDEPTH_W-1:0]  depth_m2;

    // memory ports
    logic [ENTRY_W-1:0] ent_rdata;
    logic               ent_we;
    logic [ENTRY_W-1:0] ent_wdata;
    logic [FRAME_W-1:0] frm_rdata_top;
    logic [FRAME_W-1:0] frm_rdata_par;
    logic               frm_we;
    logic [SIDX_W-1:0]  frm_waddr;
    logic [FRAME_W-1:0] frm_wdata;

    logic [TIME_BITS-1:0] e_start;
    logic [TIME_BITS-1:0] e_incl;
    logic [SELF_W-1:0]    e_self;
    logic [CALLS_W-1:0]   e_calls;
    logic [TIME_BITS-1:0] ft_start;
    logic [TIME_BITS-1:0] ft_child;
    logic [TIME_BITS-1:0] fp_start;
    logic [TIME_BITS-1:0] fp_child;

    // difference stage
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] incl_reg;
    logic [SELF_W-1:0]    self_reg;
    logic [CALLS_W-1:0]   calls_reg;
    logic [TIME_BITS-1:0] dincl_reg;
    logic [TIME_BITS-1:0] fi_reg;
    logic [SELF_W-1:0]    dself_reg;
    logic [TIME_BITS-1:0] pstart_reg;
    logic [TIME_BITS-1:0] pchild_reg;

    // write-back stage
    logic                          cur_reg;
    logic                          cur_act;
    logic [TIME_BITS-1:0]          sum_incl;
    logic [SELF_W-1:0]             sum_self;
    logic [CALLS_W-1:0]            sum_calls;
    logic [TIME_BITS-1:0]          sum_pchild;
    logic [cstp_pkg::STATUS_W-1:0] st;
    logic [TIME_BITS-1:0]          n_start;
    logic [TIME_BITS-1:0]          n_incl;
    logic [SELF_W-1:0]             n_self;
    logic [CALLS_W-1:0]            n_calls;
    logic                          reg_after;
    logic                          act_after;

    // result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [cstp_pkg::STATUS_W-1:0] status_reg;
    logic [TIME_BITS-1:0]          incl_out_reg;
    logic [SELF_W-1:0]             self_out_reg;
    logic [CALLS_W-1:0]            calls_out_reg;
    logic                          active_out_reg;
    logic                          regd_out_reg;
    logic [SDEPTH_W-1:0]           level_out_reg;

    assign s2_go     = (state_reg == S_WB) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE) || s2_go;
    assign in_accept = in_valid && in_ready;

    assign id_ext = ID_EXT_W'(func_id);
    assign idx_in = id_ext[FIDX_W-1:0];
    assign id_ok  = id_ext < ID_EXT_W'(MAX_FUNCS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                if (s2_go)
                begin
                    state_next = in_accept ? S_DIFF : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // stack reads see the depth this item leaves behind when one is finishing
    assign rd_depth  = (state_reg == S_WB) ? depth_next : depth_reg;
    assign rd_top    = rd_depth - SDEPTH_W'(1);
    assign rd_parent = rd_depth - SDEPTH_W'(2);
    assign depth_m2  = depth_reg - SDEPTH_W'(2);

    cstp_entry_ram #(
        .DEPTH (MAX_FUNCS),
        .WIDTH (ENTRY_W)
    ) u_entry_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (idx_in),
        .rd_data (ent_rdata),
        .wr_en   (ent_we && s2_go),
        .wr_addr (idx_reg),
        .wr_data (ent_wdata)
    );

    cstp_frame_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (FRAME_W)
    ) u_frame_ram (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_addr_a (rd_top[SIDX_W-1:0]),
        .rd_addr_b (rd_parent[SIDX_W-1:0]),
        .rd_data_a (frm_rdata_top),
        .rd_data_b (frm_rdata_par),
        .wr_en     (frm_we && s2_go),
        .wr_addr   (frm_waddr),
        .wr_data   (frm_wdata)
    );

    assign e_start  = ent_rdata[ENTRY_W-1 -: TIME_BITS];
    assign e_incl   = ent_rdata[ENTRY_W-TIME_BITS-1 -: TIME_BITS];
    assign e_self   = ent_rdata[CALLS_W +: SELF_W];
    assign e_calls  = ent_rdata[CALLS_W-1:0];
    assign ft_start = frm_rdata_top[FRAME_W-1 -: TIME_BITS];
    assign ft_child = frm_rdata_top[TIME_BITS-1:0];
    assign fp_start = frm_rdata_par[FRAME_W-1 -: TIME_BITS];
    assign fp_child = frm_rdata_par[TIME_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg   <= action;
            idx_reg      <= idx_in;
            valid_id_reg <= id_ok;
            ts_reg       <= timestamp;
        end
        if (state_reg == S_DIFF)
        begin
            start_reg  <= e_start;
            incl_reg   <= e_incl;
            self_reg   <= e_self;
            calls_reg  <= e_calls;
            dincl_reg  <= ts_reg - e_start;
            fi_reg     <= ts_reg - ft_start;
            dself_reg  <= e_self - SELF_W'(ft_child);
            pstart_reg <= fp_start;
            pchild_reg <= fp_child;
        end
    end

    assign cur_reg    = valid_id_reg && reg_marks_reg[idx_reg];
    assign cur_act    = act_marks_reg[idx_reg];
    assign sum_incl   = incl_reg + dincl_reg;
    assign sum_self   = dself_reg + SELF_W'(fi_reg);
    assign sum_calls  = calls_reg + CALLS_W'(1);
    assign sum_pchild = pchild_reg + fi_reg;

    always_comb
    begin
        st             = cstp_pkg::ST_DONE;
        n_start        = start_reg;
        n_incl         = incl_reg;
        n_self         = self_reg;
        n_calls        = calls_reg;
        ent_we         = 1'b0;
        frm_we         = 1'b0;
        frm_waddr      = depth_reg[SIDX_W-1:0];
        frm_wdata      = {ts_reg, TIME_BITS'(0)};
        depth_next     = depth_reg;
        reg_marks_next = reg_marks_reg;
        act_marks_next = act_marks_reg;
        reg_after      = cur_reg;
        act_after      = cur_act;
        unique case (action_reg)
            cstp_pkg::ACT_INIT:
            begin
                reg_marks_next = '0;
                reg_after      = 1'b0;
            end
            cstp_pkg::ACT_REGISTER:
            begin
                if (!valid_id_reg)
                begin
                    st = cstp_pkg::ST_NOT_REG;
                end
                else if (!cur_reg)
                begin
                    reg_marks_next[idx_reg] = 1'b1;
                    act_marks_next[idx_reg] = 1'b0;
                    n_incl    = '0;
                    n_self    = '0;
                    n_calls   = '0;
                    ent_we    = 1'b1;
                    reg_after = 1'b1;
                    act_after = 1'b0;
                end
            end
            cstp_pkg::ACT_START:
            begin
                if (!cur_reg)
                begin
                    st = cstp_pkg::ST_NOT_REG;
                end
                else if (cur_act)
                begin
                    st = cstp_pkg::ST_BAD_ACTIVE;
                end
                else
                begin
                    if (depth_reg < SDEPTH_W'(STACK_DEPTH))
                    begin
                        frm_we     = 1'b1;
                        depth_next = depth_reg + SDEPTH_W'(1);
                    end
                    else
                    begin
                        st = cstp_pkg::ST_NO_FRAME;
                    end
                    n_start = ts_reg;
                    ent_we  = 1'b1;
                    act_marks_next[idx_reg] = 1'b1;
                    act_after = 1'b1;
                end
            end
            cstp_pkg::ACT_END:
            begin
                if (!cur_reg)
                begin
                    st = cstp_pkg::ST_NOT_REG;
                end
                else if (!cur_act)
                begin
                    st = cstp_pkg::ST_BAD_ACTIVE;
                end
                else
                begin
                    n_incl  = sum_incl;
                    n_calls = sum_calls;
                    ent_we  = 1'b1;
                    act_marks_next[idx_reg] = 1'b0;
                    act_after = 1'b0;
                    if (depth_reg != '0)
                    begin
                        depth_next = depth_reg - SDEPTH_W'(1);
                        n_self     = sum_self;
                        // child time of the new top frame grows by the popped frame
                        if (depth_reg > SDEPTH_W'(1))
                        begin
                            frm_we    = 1'b1;
                            frm_waddr = depth_m2[SIDX_W-1:0];
                            frm_wdata = {pstart_reg, sum_pchild};
                        end
                    end
                    else
                    begin
                        st = cstp_pkg::ST_NO_FRAME;
                    end
                end
            end
            default:
            begin
                if (!cur_reg)
                begin
                    st = cstp_pkg::ST_NOT_REG;
                end
            end
        endcase
    end

    assign ent_wdata = {n_start, n_incl, n_self, n_calls};

    assign out_valid_next = s2_go || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            reg_marks_reg <= '0;
            act_marks_reg <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (s2_go)
            begin
                reg_marks_reg <= reg_marks_next;
                act_marks_reg <= act_marks_next;
                depth_reg     <= depth_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go)
        begin
            status_reg     <= st;
            incl_out_reg   <= reg_after ? n_incl : '0;
            self_out_reg   <= reg_after ? n_self : '0;
            calls_out_reg  <= reg_after ? n_calls : '0;
            active_out_reg <= reg_after && act_after;
            regd_out_reg   <= reg_after;
            level_out_reg  <= depth_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign inclusive_total = incl_out_reg;
    assign self_total      = self_out_reg;
    assign calls           = calls_out_reg;
    assign is_active       = active_out_reg;
    assign is_registered   = regd_out_reg;
    assign stack_level     = level_out_reg;

endmodule

// ----- rtl/cstp_checker.sv -----
// port-level checks of the call stack profiler and their binding
`include "assert_macros.svh"

module cstp_checker #(
    parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = cstp_pkg::TIME_BITS_DEF,
    localparam int SDEPTH_W   = $clog2(STACK_DEPTH + 1)
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [cstp_pkg::STATUS_W-1:0] status,
    input logic [TIME_BITS-1:0]          inclusive_total,
    input logic signed [TIME_BITS:0]     self_total,
    input logic [cstp_pkg::CALLS_W-1:0]  calls,
    input logic                          is_active,
    input logic                          is_registered,
    input logic [SDEPTH_W-1:0]           stack_level
);

    // no result while in reset
    `ASSERT_CLK(a_rst_quiet, clk, !rst_n |-> !out_valid)

    // a stalled result holds
    `ASSERT_CLKD(a_out_hold, clk, rst_n,
                 out_valid && !out_ready |=>
                 out_valid && $stable(status) && $stable(stack_level) && $stable(calls))

    `ASSERT_CLKD(a_level_max, clk, rst_n, out_valid |-> stack_level <= SDEPTH_W'(STACK_DEPTH))

    // unregistered entries report nothing
    `ASSERT_CLKD(a_unreg_zero, clk, rst_n,
                 out_valid && !is_registered |->
                 inclusive_total == '0 && self_total == '0 && calls == '0 && !is_active)

    `ASSERT_CLKD(a_notreg_status, clk, rst_n,
                 out_valid && status == cstp_pkg::ST_NOT_REG |-> !is_registered)

endmodule

bind call_stack_self_time_profiler cstp_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .TIME_BITS   (TIME_BITS)
) u_cstp_checker (.*);
